// ===== design/psds_pkg.sv =====
`timescale 1ns / 1ps

package psds_pkg;

  // Field widths fixed by the item formats.
  localparam int unsigned COORD_W = 16;
  localparam int unsigned ABS_W   = COORD_W + 1;
  localparam int unsigned SQ_W    = 2 * ABS_W;
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned MEAN_W  = 25;

  // Square root: the radicand is the squared distance with 16 fraction bits,
  // padded to an even number of bits; two result bits are resolved per cycle.
  localparam int unsigned RAD_W    = 52;
  localparam int unsigned ROOT_W   = RAD_W / 2;
  localparam int unsigned REM_W    = ROOT_W + 3;
  localparam int unsigned ROOT_CYC = ROOT_W / 2;

  // Configuration register indexes.
  localparam logic CFG_REF_X = 1'b0;
  localparam logic CFG_REF_Y = 1'b1;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      last_point;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]  nearest_index;
    logic              nearest_tie;
    logic [IDX_W-1:0]  farthest_index;
    logic              farthest_tie;
    logic [MEAN_W-1:0] mean_distance;
  } out_item_t;

  // Word passed from the front to the back through the queue.
  typedef struct packed {
    logic [ABS_W-1:0] abs_x;
    logic [ABS_W-1:0] abs_y;
    logic             measure;
    logic             last;
  } q_entry_t;

endpackage

// ===== design/psds_front.sv =====
`timescale 1ns / 1ps

module psds_front import psds_pkg::*; #(
  parameter int unsigned MAX_POINTS = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic               cfg_index_i,
  input  logic [COORD_W-1:0] cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_item_t           in_data_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output q_entry_t           q_entry_o
);

  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);

  logic [COORD_W-1:0] ref_x_q, ref_y_q;
  logic [CNT_W-1:0]   cnt_q;
  logic signed [ABS_W-1:0] dx, dy;
  logic accept;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign q_push_o   = accept;

  // Differences to the reference point and their magnitudes.
  always_comb begin
    dx = $signed({ref_x_q[COORD_W-1], ref_x_q})
       - $signed({in_data_i.point_x[COORD_W-1], in_data_i.point_x});
    dy = $signed({ref_y_q[COORD_W-1], ref_y_q})
       - $signed({in_data_i.point_y[COORD_W-1], in_data_i.point_y});
    q_entry_o.abs_x   = dx[ABS_W-1] ? ABS_W'(-dx) : ABS_W'(dx);
    q_entry_o.abs_y   = dy[ABS_W-1] ? ABS_W'(-dy) : ABS_W'(dy);
    q_entry_o.measure = (cnt_q < CNT_W'(MAX_POINTS));
    q_entry_o.last    = in_data_i.last_point;
  end

  // Reference registers and the set fill count that decides dropping.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_x_q <= '0;
      ref_y_q <= '0;
      cnt_q   <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_REF_X: ref_x_q <= cfg_data_i;
          CFG_REF_Y: ref_y_q <= cfg_data_i;
          default:   ;
        endcase
      end
      if (accept) begin
        if (in_data_i.last_point) begin
          cnt_q <= '0;
        end else if (q_entry_o.measure) begin
          cnt_q <= cnt_q + CNT_W'(1);
        end
      end
    end
  end

endmodule

// ===== design/psds_queue.sv =====
`timescale 1ns / 1ps

module psds_queue import psds_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  q_entry_t push_entry_i,
  output logic     full_o,
  output logic     valid_o,
  input  logic     pop_i,
  output q_entry_t pop_entry_o
);

  localparam int unsigned DEPTH = 2;

  q_entry_t   mem_q [DEPTH];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o      = (cnt_q == 2'(DEPTH));
  assign valid_o     = (cnt_q != 2'd0);
  assign pop_entry_o = mem_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && valid_o;

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

// ===== design/psds_back.sv =====
`timescale 1ns / 1ps

module psds_back import psds_pkg::*; #(
  parameter int unsigned MAX_POINTS = 1024
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_valid_i,
  output logic      q_pop_o,
  input  q_entry_t  q_entry_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  localparam int unsigned CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int unsigned SUM_W  = MEAN_W + CNT_W;
  localparam int unsigned DIVC_W = $clog2(SUM_W);
  localparam int unsigned RCNT_W = $clog2(ROOT_CYC);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SQUARE, ST_CMP, ST_ROOT, ST_ACC, ST_DIV, ST_DONE
  } state_e;

  state_e state_q;
  q_entry_t ent_q;
  logic [SQ_W-1:0]   sqx_q, sqy_q, min_q, max_q;
  logic [IDX_W-1:0]  min_idx_q, max_idx_q;
  logic              min_tie_q, max_tie_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [SUM_W-1:0]  sum_q, div_q;
  logic [CNT_W-1:0]  drem_q;
  logic [DIVC_W-1:0] dstep_q;
  logic [RAD_W-1:0]  rad_q;
  logic [ROOT_W-1:0] root_q;
  logic [REM_W-1:0]  rem_q;
  logic [RCNT_W-1:0] rstep_q;
  logic              out_valid_q;
  out_item_t         out_q;

  logic [SQ_W-1:0]   d2;
  logic [IDX_W-1:0]  idx;
  logic [REM_W-1:0]  r1, r2, t1, t2, rem_d;
  logic [ROOT_W-1:0] root1, root_d;
  logic [REM_W-1:0]  rem1;
  logic [SUM_W-1:0]  sum_d;
  logic [CNT_W:0]    dtrial;
  logic              load_out;

  assign q_pop_o     = (state_q == ST_IDLE) && q_valid_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Squared distance, point index and running sum.
  assign d2    = sqx_q + sqy_q;
  assign idx   = IDX_W'(cnt_q);
  assign sum_d = sum_q + SUM_W'(root_q);
  assign load_out = !out_valid_q || !out_stall_i;

  // Two digit steps of the square root per cycle.
  always_comb begin
    r1 = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
    t1 = {1'b0, root_q, 2'b01};
    if (r1 >= t1) begin
      rem1  = r1 - t1;
      root1 = {root_q[ROOT_W-2:0], 1'b1};
    end else begin
      rem1  = r1;
      root1 = {root_q[ROOT_W-2:0], 1'b0};
    end
    r2 = {rem1[REM_W-3:0], rad_q[RAD_W-3 -: 2]};
    t2 = {1'b0, root1, 2'b01};
    if (r2 >= t2) begin
      rem_d  = r2 - t2;
      root_d = {root1[ROOT_W-2:0], 1'b1};
    end else begin
      rem_d  = r2;
      root_d = {root1[ROOT_W-2:0], 1'b0};
    end
  end

  // One quotient bit per cycle of the restoring divider.
  assign dtrial = {drem_q, div_q[SUM_W-1]};

  // Sequencer for measurement, accumulation, division and result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ent_q       <= '0;
      sqx_q       <= '0;
      sqy_q       <= '0;
      min_q       <= '1;
      max_q       <= '0;
      min_idx_q   <= '0;
      max_idx_q   <= '0;
      min_tie_q   <= 1'b0;
      max_tie_q   <= 1'b0;
      cnt_q       <= '0;
      sum_q       <= '0;
      div_q       <= '0;
      drem_q      <= '0;
      dstep_q     <= '0;
      rad_q       <= '0;
      root_q      <= '0;
      rem_q       <= '0;
      rstep_q     <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      // The result state reloads the output register itself.
      if (out_valid_q && !out_stall_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (q_valid_i) begin
            ent_q <= q_entry_i;
            if (q_entry_i.measure) begin
              state_q <= ST_SQUARE;
            end else if (q_entry_i.last) begin
              div_q   <= sum_q;
              drem_q  <= '0;
              dstep_q <= '0;
              state_q <= ST_DIV;
            end
          end
        end
        ST_SQUARE: begin
          sqx_q   <= ent_q.abs_x * ent_q.abs_x;
          sqy_q   <= ent_q.abs_y * ent_q.abs_y;
          state_q <= ST_CMP;
        end
        ST_CMP: begin
          if (cnt_q == '0) begin
            min_q     <= d2;
            min_idx_q <= idx;
            max_q     <= d2;
            max_idx_q <= idx;
          end else begin
            if (d2 < min_q) begin
              min_q     <= d2;
              min_idx_q <= idx;
            end else if (d2 == min_q) begin
              min_tie_q <= 1'b1;
            end
            if (d2 > max_q) begin
              max_q     <= d2;
              max_idx_q <= idx;
            end else if (d2 == max_q) begin
              max_tie_q <= 1'b1;
            end
          end
          rad_q   <= {2'b00, d2, 16'd0};
          root_q  <= '0;
          rem_q   <= '0;
          rstep_q <= '0;
          state_q <= ST_ROOT;
        end
        ST_ROOT: begin
          rad_q   <= rad_q << 4;
          root_q  <= root_d;
          rem_q   <= rem_d;
          rstep_q <= rstep_q + RCNT_W'(1);
          if (rstep_q == RCNT_W'(ROOT_CYC - 1)) begin
            state_q <= ST_ACC;
          end
        end
        ST_ACC: begin
          sum_q <= sum_d;
          cnt_q <= cnt_q + CNT_W'(1);
          if (ent_q.last) begin
            div_q   <= sum_d;
            drem_q  <= '0;
            dstep_q <= '0;
            state_q <= ST_DIV;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_DIV: begin
          if (dtrial >= {1'b0, cnt_q}) begin
            drem_q <= CNT_W'(dtrial - {1'b0, cnt_q});
            div_q  <= {div_q[SUM_W-2:0], 1'b1};
          end else begin
            drem_q <= CNT_W'(dtrial);
            div_q  <= {div_q[SUM_W-2:0], 1'b0};
          end
          dstep_q <= dstep_q + DIVC_W'(1);
          if (dstep_q == DIVC_W'(SUM_W - 1)) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (load_out) begin
            out_valid_q          <= 1'b1;
            out_q.nearest_index  <= min_tie_q ? '0 : min_idx_q;
            out_q.nearest_tie    <= min_tie_q;
            out_q.farthest_index <= max_tie_q ? '0 : max_idx_q;
            out_q.farthest_tie   <= max_tie_q;
            out_q.mean_distance  <= MEAN_W'(div_q);
            // Clear the set for the next one.
            cnt_q     <= '0;
            min_q     <= '1;
            min_idx_q <= '0;
            min_tie_q <= 1'b0;
            max_q     <= '0;
            max_idx_q <= '0;
            max_tie_q <= 1'b0;
            sum_q     <= '0;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== design/point_set_distance_stats_top.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake                 Word
// input     in         in_valid_i / in_stall_o   in_data_i  (in_item_t)
// output    out        out_valid_o / out_stall_i out_data_o (out_item_t)
// config    in         cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// For each measured point the back end squares, compares, takes the square
// root two result bits per cycle and accumulates. A set's last point adds
// a restoring division of the 25 + clog2(MAX_POINTS+1) bit sum (36 by
// default), one quotient bit per cycle, and then loads the result.
// A two-word queue holds input words while the back end works or a result
// waits on out_stall_i. Reset is asynchronous and clears all control state
// and the reference point; no clearing pass is needed.

module point_set_distance_stats_top import psds_pkg::*; #(
  parameter int unsigned MAX_POINTS = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [COORD_W-1:0] cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_item_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_item_t          out_data_o
);

  logic     q_full, q_push, q_valid, q_pop;
  q_entry_t q_push_entry, q_pop_entry;

  assign cfg_ready_o = 1'b1;

  // Front: reference registers, differences and drop decision.
  psds_front #(
    .MAX_POINTS(MAX_POINTS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_entry_o  (q_push_entry)
  );

  // Queue between front and back.
  psds_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_entry_i(q_push_entry),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .pop_i       (q_pop),
    .pop_entry_o (q_pop_entry)
  );

  // Back: distance, square root, searches, mean and result register.
  psds_back #(
    .MAX_POINTS(MAX_POINTS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_pop_o    (q_pop),
    .q_entry_i  (q_pop_entry),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import psds_pkg::*;

  localparam int unsigned POINT_CAP   = 1024;
  localparam int unsigned CYCLE_LIMIT = 2000000;
  // Worst case back end: one point, one division, one result load, with margin.
  localparam int unsigned SETTLE      = 80;
  localparam int unsigned PHASE_ITEMS = 40;

  typedef enum logic [1:0] {
    SPREAD_FULL,
    SPREAD_NEAR,
    SPREAD_EDGE
  } spread_e;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_COIN,
    STALL_RUNS,
    STALL_HEAVY
  } stall_mode_e;

  // Tracks the running nearest, farthest and distance sum of the current set
  // and holds the statistics expected for every closed set.
  class set_stats_board;
    logic signed [COORD_W-1:0] ref_x;
    logic signed [COORD_W-1:0] ref_y;
    int unsigned cap;
    int unsigned point_count;
    longint min_sq;
    longint max_sq;
    int unsigned min_at;
    int unsigned max_at;
    bit min_tied;
    bit max_tied;
    longint unsigned root_sum;
    out_item_t expected_stats[$];
    int unsigned fails;

    function new(int unsigned cap_points);
      cap = cap_points;
      ref_x = '0;
      ref_y = '0;
      fails = 0;
      clear_set();
    endfunction

    function void clear_set();
      point_count = 0;
      min_sq = 64'h3_FFFF_FFFF;
      max_sq = 0;
      min_at = 0;
      max_at = 0;
      min_tied = 1'b0;
      max_tied = 1'b0;
      root_sum = 0;
    endfunction

    function void set_ref(logic idx, logic [COORD_W-1:0] value);
      if (idx == CFG_REF_X) ref_x = value;
      else ref_y = value;
    endfunction

    // Truncated square root with 8 fraction bits, found one bit at a time.
    static function longint unsigned root_q8(longint unsigned d2);
      longint unsigned rad;
      longint unsigned root;
      longint unsigned trial;
      rad = d2 << 16;
      root = 0;
      for (int b = ROOT_W - 1; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if (trial * trial <= rad) root = trial;
      end
      return root;
    endfunction

    function void note_point(in_item_t w);
      longint dx;
      longint dy;
      longint d2;
      out_item_t stats;
      // Points beyond the capacity are dropped, but a last mark still counts.
      if (point_count < cap) begin
        dx = longint'(ref_x) - longint'($signed(w.point_x));
        dy = longint'(ref_y) - longint'($signed(w.point_y));
        d2 = dx * dx + dy * dy;
        if (point_count == 0) begin
          min_sq = d2;
          max_sq = d2;
          min_at = 0;
          max_at = 0;
        end else begin
          if (d2 < min_sq) begin
            min_sq = d2;
            min_at = point_count;
          end else if (d2 == min_sq) begin
            min_tied = 1'b1;
          end
          if (d2 > max_sq) begin
            max_sq = d2;
            max_at = point_count;
          end else if (d2 == max_sq) begin
            max_tied = 1'b1;
          end
        end
        root_sum += root_q8(longint'(d2));
        point_count++;
      end
      if (w.last_point) begin
        stats.nearest_index  = min_tied ? '0 : IDX_W'(min_at);
        stats.nearest_tie    = min_tied;
        stats.farthest_index = max_tied ? '0 : IDX_W'(max_at);
        stats.farthest_tie   = max_tied;
        stats.mean_distance  = MEAN_W'(root_sum / point_count);
        expected_stats.push_back(stats);
        clear_set();
      end
    endfunction

    function void check_stats(out_item_t got);
      out_item_t want;
      if (expected_stats.size() == 0) begin
        if (fails < 10) $display("unexpected result word %h", got);
        fails++;
        return;
      end
      want = expected_stats.pop_front();
      if (got.nearest_index !== want.nearest_index || got.nearest_tie !== want.nearest_tie ||
          got.farthest_index !== want.farthest_index ||
          got.farthest_tie !== want.farthest_tie ||
          got.mean_distance !== want.mean_distance) begin
        if (fails < 10) begin
          $display("mismatch: expected near %0d/%0d far %0d/%0d mean %0d",
                   want.nearest_index, want.nearest_tie, want.farthest_index,
                   want.farthest_tie, want.mean_distance);
          $display("          actual   near %0d/%0d far %0d/%0d mean %0d",
                   got.nearest_index, got.nearest_tie, got.farthest_index,
                   got.farthest_tie, got.mean_distance);
        end
        fails++;
      end
    endfunction

    function int unsigned pending();
      return expected_stats.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = CFG_REF_X;
  logic [COORD_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;

  set_stats_board sb = new(POINT_CAP);

  int unsigned cycle_count = 0;
  int unsigned burst_left = 1;
  bit no_gaps = 1'b0;
  stall_mode_e stall_mode = STALL_NONE;
  int unsigned stall_left = 0;

  point_set_distance_stats_top #(
    .MAX_POINTS(POINT_CAP)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  always #6 clk = ~clk;

  // Cycle budget for the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver back-pressure in a pattern that is redrawn at random during the run.
  always @(posedge clk) begin
    if (cycle_count % 1500 == 0) stall_mode <= stall_mode_e'($urandom_range(0, 3));
    case (stall_mode)
      STALL_NONE: out_stall <= 1'b0;
      STALL_COIN: out_stall <= ($urandom_range(0, 1) == 1);
      STALL_RUNS: begin
        if (stall_left != 0) begin
          stall_left <= stall_left - 1;
        end else begin
          out_stall <= !out_stall;
          stall_left <= out_stall ? $urandom_range(0, 5) : $urandom_range(1, 40);
        end
      end
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // Results are sampled on the falling edge before the rising edge that takes them.
  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_stats(out_data);
  end

  function automatic logic signed [COORD_W-1:0] pick_coord(logic signed [COORD_W-1:0] center,
                                                            spread_e spread);
    case (spread)
      SPREAD_NEAR: return COORD_W'(int'(center) + int'($urandom_range(0, 8)) - 4);
      SPREAD_EDGE: begin
        case ($urandom_range(0, 4))
          0: return 16'sh8000;
          1: return -16'sd1;
          2: return 16'sd0;
          3: return 16'sd1;
          default: return 16'sh7fff;
        endcase
      end
      default: return COORD_W'($urandom);
    endcase
  endfunction

  // Sends one point word and then, at the end of a burst, idles for a random gap.
  task automatic send_point(input logic signed [COORD_W-1:0] x,
                            input logic signed [COORD_W-1:0] y, input logic last);
    in_item_t w;
    bit taken;
    int unsigned gap;
    w.point_x = x;
    w.point_y = y;
    w.last_point = last;
    in_valid <= 1'b1;
    in_data <= w;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    sb.note_point(w);
    if (no_gaps || burst_left > 1) begin
      if (burst_left > 1) burst_left--;
    end else begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
  endtask

  task automatic send_random_set(input int unsigned size);
    spread_e spread;
    spread = spread_e'($urandom_range(0, 2));
    for (int unsigned i = 0; i < size; i++) begin
      if ($urandom_range(0, 7) == 0) spread = spread_e'($urandom_range(0, 2));
      send_point(pick_coord(sb.ref_x, spread), pick_coord(sb.ref_y, spread), i == size - 1);
    end
  endtask

  // Waits until every set has reported and the back end has gone quiet.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Writes both reference coordinates back to back.
  task automatic write_ref(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    bit taken;
    cfg_valid <= 1'b1;
    cfg_index <= CFG_REF_X;
    cfg_data <= x;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
    sb.set_ref(CFG_REF_X, x);
    cfg_index <= CFG_REF_Y;
    cfg_data <= y;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
    sb.set_ref(CFG_REF_Y, y);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    int unsigned sent;
    int unsigned size;
    write_ref(x, y);
    no_gaps = ($urandom_range(0, 3) == 0);
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      size = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      if ($urandom_range(0, 19) == 0) no_gaps = !no_gaps;
      send_random_set(size);
      sent += size;
    end
    wait_idle();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reference at its reset value: a lone point at zero distance.
    send_point(16'sd0, 16'sd0, 1'b1);
    // Corner points, the largest distances from the origin.
    send_point(16'sh7fff, 16'sh7fff, 1'b0);
    send_point(16'sh8000, 16'sh8000, 1'b0);
    send_point(16'sh8000, 16'sh7fff, 1'b1);
    // Four points on one circle: both searches tie.
    send_point(16'sd3, 16'sd4, 1'b0);
    send_point(16'sd5, 16'sd0, 1'b0);
    send_point(16'sd0, -16'sd5, 1'b0);
    send_point(-16'sd4, -16'sd3, 1'b1);
    // Only the nearest search ties.
    send_point(16'sd1, 16'sd0, 1'b0);
    send_point(16'sd2, 16'sd0, 1'b0);
    send_point(16'sd1, 16'sd0, 1'b1);
    // A later point takes the minimum.
    send_point(-16'sd1, -16'sd1, 1'b0);
    send_point(16'sd0, 16'sd0, 1'b1);
    wait_idle();

    // Reference in opposite corners, so that the distance reaches its top.
    write_ref(16'h8000, 16'h8000);
    send_point(16'sh7fff, 16'sh7fff, 1'b1);
    send_point(16'sh8000, 16'sh8000, 1'b0);
    send_point(16'sh7fff, 16'sh8000, 1'b1);
    wait_idle();
    write_ref(16'h7fff, 16'h8000);
    send_point(16'sh8000, 16'sh7fff, 1'b1);
    send_point(16'sh7fff, 16'sh8000, 1'b0);
    send_point(16'sd0, 16'sd0, 1'b0);
    send_point(-16'sd1, -16'sd1, 1'b1);
    wait_idle();

    // Random sets under several reference points.
    run_phase(COORD_W'($urandom), COORD_W'($urandom));
    run_phase(16'h8000, 16'h7fff);
    run_phase(COORD_W'($urandom), COORD_W'($urandom));
    run_phase(16'h7fff, 16'h7fff);
    run_phase(COORD_W'($urandom), COORD_W'($urandom));

    // One set past the capacity, closed by a dropped point, then a short set.
    write_ref(COORD_W'($urandom), COORD_W'($urandom));
    no_gaps = 1'b0;
    send_random_set(POINT_CAP + 3);
    send_random_set(3);
    wait_idle();

    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
